FILE: sv/sfdl_pkg.sv
// Shared widths, types and constants of the stereo fractional delay line.
package sfdl_pkg;

  localparam int unsigned STORE_DEPTH   = 4096;
  localparam int unsigned SAMPLE_BITS   = 24;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned ADDR_BITS     = $clog2(STORE_DEPTH);
  localparam int unsigned LEN_BITS      = ADDR_BITS + 1;
  localparam int unsigned DELAY_BITS    = ADDR_BITS + FRACTION_BITS;
  localparam int unsigned PROD_BITS     = SAMPLE_BITS + FRACTION_BITS + 2;
  localparam int unsigned MIN_RING      = 3;
  localparam int unsigned GUARD_FRAMES  = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SAMPLE_BITS:0]   diff_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic [FRACTION_BITS-1:0]      frac_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic [LEN_BITS-1:0]           len_t;
  typedef logic [DELAY_BITS-1:0]         delay_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

  localparam len_t  RING_MIN   = len_t'(MIN_RING);
  localparam len_t  RING_MAX   = len_t'(STORE_DEPTH);
  localparam len_t  GUARD      = len_t'(GUARD_FRAMES);
  localparam addr_t SPAN_MAX   = addr_t'(STORE_DEPTH - GUARD_FRAMES);
  localparam prod_t ROUND_HALF = prod_t'(64'd1 << (FRACTION_BITS - 1));

endpackage

FILE: sv/sfdl_if.sv
// Valid/ready channel interfaces for input frames and delayed output frames.
interface sfdl_in_if;
  logic                     valid;
  logic                     ready;
  sfdl_pkg::sample_t        left_in;
  sfdl_pkg::sample_t        right_in;
  sfdl_pkg::delay_t         delay_in;
  logic                     delay_bad;

  modport source (output valid, output left_in, output right_in, output delay_in,
                  output delay_bad, input ready);
  modport sink   (input valid, input left_in, input right_in, input delay_in,
                  input delay_bad, output ready);
endinterface

interface sfdl_out_if;
  logic                     valid;
  logic                     ready;
  sfdl_pkg::sample_t        left_out;
  sfdl_pkg::sample_t        right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

FILE: sv/sfdl_ram.sv
// Stereo sample store: one write port, two registered read ports, read-first.
module sfdl_ram (
  input  logic                clk,
  input  logic                rd_en,
  input  sfdl_pkg::addr_t     ra0,
  input  sfdl_pkg::addr_t     ra1,
  output sfdl_pkg::frame_t    rd0,
  output sfdl_pkg::frame_t    rd1,
  input  logic                we,
  input  sfdl_pkg::addr_t     wa,
  input  sfdl_pkg::frame_t    wd
);

  sfdl_pkg::frame_t mem_r [sfdl_pkg::STORE_DEPTH];
  sfdl_pkg::frame_t rd0_r;
  sfdl_pkg::frame_t rd1_r;

  // reads return the old entry when the same address is written
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd0_r <= mem_r[ra0];
      rd1_r <= mem_r[ra1];
    end
    if (we) begin
      mem_r[wa] <= wd;
    end
  end

  assign rd0 = rd0_r;
  assign rd1 = rd1_r;

endmodule

FILE: sv/sfdl_blend.sv
// One channel of linear interpolation: difference, multiply with rounding, add.
module sfdl_blend (
  input  logic                clk,
  input  logic                en,
  input  sfdl_pkg::sample_t   a_i,
  input  sfdl_pkg::sample_t   b_i,
  input  sfdl_pkg::frac_t     frac_i,
  output sfdl_pkg::sample_t   y_o
);

  sfdl_pkg::sample_t a1_r;
  sfdl_pkg::diff_t   d1_r;
  sfdl_pkg::frac_t   f1_r;
  sfdl_pkg::sample_t a2_r;
  sfdl_pkg::prod_t   p2_r;
  sfdl_pkg::prod_t   step;
  sfdl_pkg::prod_t   total;

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= a_i;
      d1_r <= sfdl_pkg::diff_t'(b_i) - sfdl_pkg::diff_t'(a_i);
      f1_r <= frac_i;
      a2_r <= a1_r;
      p2_r <= sfdl_pkg::prod_t'(d1_r) * sfdl_pkg::prod_t'({1'b0, f1_r})
              + sfdl_pkg::ROUND_HALF;
    end
  end

  // floor shift; result lies between a and b so it fits the sample width
  always_comb begin
    step  = p2_r >>> sfdl_pkg::FRACTION_BITS;
    total = sfdl_pkg::prod_t'(a2_r) + step;
    y_o   = total[sfdl_pkg::SAMPLE_BITS-1:0];
  end

endmodule

FILE: sv/sfdl_outq.sv
// Two-entry output buffer (main register plus skid) driving the result channel.
module sfdl_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  sfdl_pkg::frame_t    data_i,
  output logic                ready_o,
  sfdl_out_if.source          out_ch
);

  logic             main_v_r;
  logic             skid_v_r;
  sfdl_pkg::frame_t main_d_r;
  sfdl_pkg::frame_t skid_d_r;
  logic             take;

  assign take = !main_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take) begin
      main_v_r <= skid_v_r || push_i;
      skid_v_r <= 1'b0;
    end else if (push_i) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      main_d_r <= skid_v_r ? skid_d_r : data_i;
    end
    if (!take && push_i) begin
      skid_d_r <= data_i;
    end
  end

  assign ready_o          = !skid_v_r;
  assign out_ch.valid     = main_v_r;
  assign out_ch.left_out  = main_d_r.left;
  assign out_ch.right_out = main_d_r.right;

endmodule

FILE: sv/stereo_fractional_delay_line.sv
// Top level of the stereo fractional delay line with linear interpolation.
//
//   channel  | dir | handshake       | content
//   ---------+-----+-----------------+---------------------------------------------
//   in_ch    | in  | valid/ready     | left_in, right_in, delay_in, delay_bad
//   out_ch   | out | valid/ready     | left_out, right_out
//   cfg_*    | in  | write enable    | ring_length (clamped to 3..STORE_DEPTH)
//
// One frame per clock unless out_ch backpressure fills the skid; a result passes
// the input register, RAM read, subtract and multiply stages and output register.
// Reset is synchronous (rst_n low); no clearing pass: a high-water mark of written
// entries makes unwritten entries read as zero.
// Output backpressure parks one frame in the skid register, then in_ch.ready drops
// (in_ch.ready is a register output).
module stereo_fractional_delay_line (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [sfdl_pkg::LEN_BITS-1:0] cfg_wdata,
  sfdl_in_if.sink                   in_ch,
  sfdl_out_if.source                out_ch
);

  // ring position arithmetic: (pos - offs) mod len, offs < len
  function automatic sfdl_pkg::addr_t ring_back(input sfdl_pkg::addr_t pos,
                                                input sfdl_pkg::addr_t offs,
                                                input sfdl_pkg::len_t  len);
    sfdl_pkg::len_t wrapped;
    wrapped = sfdl_pkg::len_t'(pos) + len - sfdl_pkg::len_t'(offs);
    if (pos >= offs) return pos - offs;
    else             return wrapped[sfdl_pkg::ADDR_BITS-1:0];
  endfunction

  logic              en;

  // configuration and write pointer
  sfdl_pkg::len_t    len_r;
  sfdl_pkg::len_t    len_nxt;
  sfdl_pkg::len_t    lenm2_full;
  sfdl_pkg::addr_t   lenm2_r;
  sfdl_pkg::addr_t   wp_r;
  sfdl_pkg::addr_t   wp_nxt;
  sfdl_pkg::len_t    wp_inc;
  sfdl_pkg::len_t    hw_r;

  // input stage: clamp delay, split into whole frames and fraction
  sfdl_pkg::delay_t  max_delay;
  sfdl_pkg::delay_t  dclamp;
  sfdl_pkg::addr_t   dint;
  sfdl_pkg::frac_t   dfrac;
  logic              borrow;
  sfdl_pkg::addr_t   back_nxt;
  sfdl_pkg::addr_t   bk1_nxt;
  sfdl_pkg::frac_t   frac_nxt;
  logic              zero_nxt;

  logic              vp_r;
  sfdl_pkg::frame_t  p_in_r;
  sfdl_pkg::addr_t   p_back_r;
  sfdl_pkg::addr_t   p_bk1_r;
  sfdl_pkg::frac_t   p_frac_r;
  logic              p_zero_r;
  logic              p_mute_r;

  // issue stage: RAM read of both taps and write of the new frame
  sfdl_pkg::addr_t   rd_first;
  sfdl_pkg::addr_t   rd_next;
  logic              first_ok;
  logic              next_ok;
  logic              ram_we;
  sfdl_pkg::frame_t  q_first;
  sfdl_pkg::frame_t  q_next;

  // RAM data stage
  logic              v1_r;
  logic              s1_mute_r;
  logic              s1_zero_r;
  logic              s1_va_r;
  logic              s1_vb_r;
  sfdl_pkg::frac_t   s1_frac_r;
  sfdl_pkg::frame_t  s1_in_r;
  sfdl_pkg::frame_t  sel_a;
  sfdl_pkg::frame_t  sel_b;
  sfdl_pkg::frac_t   sel_frac;

  // blend stages
  logic              sa_v_r;
  logic              sb_v_r;
  sfdl_pkg::frame_t  blend_y;
  logic              push;

  // ---------------------------------------------------------------------------
  // configuration clamp
  always_comb begin
    priority if (cfg_wdata < sfdl_pkg::RING_MIN) len_nxt = sfdl_pkg::RING_MIN;
    else if (cfg_wdata > sfdl_pkg::RING_MAX)     len_nxt = sfdl_pkg::RING_MAX;
    else                                         len_nxt = cfg_wdata;
    lenm2_full = len_nxt - sfdl_pkg::GUARD;
  end

  // ---------------------------------------------------------------------------
  // input stage combinational: delay clamp to ring length minus two
  always_comb begin
    max_delay = {lenm2_r, sfdl_pkg::frac_t'(0)};
    dclamp    = (in_ch.delay_in > max_delay) ? max_delay : in_ch.delay_in;
    dint      = dclamp[sfdl_pkg::DELAY_BITS-1:sfdl_pkg::FRACTION_BITS];
    dfrac     = dclamp[sfdl_pkg::FRACTION_BITS-1:0];
    borrow    = |dfrac;
    // read position = wp - dint - borrow with fraction (-dfrac); next tap one later
    back_nxt  = dint + sfdl_pkg::addr_t'(borrow);
    bk1_nxt   = borrow ? dint : dint - sfdl_pkg::addr_t'(1);
    frac_nxt  = sfdl_pkg::frac_t'(0) - dfrac;
    zero_nxt  = (dclamp == '0);
  end

  // ---------------------------------------------------------------------------
  // issue stage combinational
  always_comb begin
    rd_first = ring_back(wp_r, p_back_r, len_r);
    rd_next  = ring_back(wp_r, p_bk1_r, len_r);
    // entries at or above the high-water mark were never written: read as zero
    first_ok = sfdl_pkg::len_t'(rd_first) < hw_r;
    next_ok  = sfdl_pkg::len_t'(rd_next) < hw_r;
    ram_we   = en && vp_r && !p_mute_r;
    wp_inc   = sfdl_pkg::len_t'(wp_r) + sfdl_pkg::len_t'(1);
    wp_nxt   = (wp_inc == len_r) ? '0 : wp_inc[sfdl_pkg::ADDR_BITS-1:0];
  end

  // reads and the write of one frame share the same edge; the RAM is read-first,
  // and the next frame reads at a later edge, so no forwarding is needed
  sfdl_ram u_ram (
    .clk   (clk),
    .rd_en (en),
    .ra0   (rd_first),
    .ra1   (rd_next),
    .rd0   (q_first),
    .rd1   (q_next),
    .we    (ram_we),
    .wa    (wp_r),
    .wd    (p_in_r)
  );

  // ---------------------------------------------------------------------------
  // tap selection: muted frames blend zeros, zero delay blends the input with itself
  always_comb begin
    priority if (s1_mute_r) begin
      sel_a    = '0;
      sel_b    = '0;
      sel_frac = '0;
    end else if (s1_zero_r) begin
      sel_a    = s1_in_r;
      sel_b    = s1_in_r;
      sel_frac = '0;
    end else begin
      sel_a.left  = s1_va_r ? q_first.left  : '0;
      sel_a.right = s1_va_r ? q_first.right : '0;
      sel_b.left  = s1_vb_r ? q_next.left   : '0;
      sel_b.right = s1_vb_r ? q_next.right  : '0;
      sel_frac    = s1_frac_r;
    end
  end

  sfdl_blend u_blend_l (
    .clk    (clk),
    .en     (en),
    .a_i    (sel_a.left),
    .b_i    (sel_b.left),
    .frac_i (sel_frac),
    .y_o    (blend_y.left)
  );

  sfdl_blend u_blend_r (
    .clk    (clk),
    .en     (en),
    .a_i    (sel_a.right),
    .b_i    (sel_b.right),
    .frac_i (sel_frac),
    .y_o    (blend_y.right)
  );

  assign push = en && sb_v_r;

  sfdl_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .data_i (blend_y),
    .ready_o(en),
    .out_ch (out_ch)
  );

  assign in_ch.ready = en;

  // ---------------------------------------------------------------------------
  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= sfdl_pkg::RING_MAX;
      lenm2_r <= sfdl_pkg::SPAN_MAX;
      wp_r    <= '0;
      hw_r    <= '0;
      vp_r    <= 1'b0;
      v1_r    <= 1'b0;
      sa_v_r  <= 1'b0;
      sb_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        len_r   <= len_nxt;
        lenm2_r <= lenm2_full[sfdl_pkg::ADDR_BITS-1:0];
        wp_r    <= '0;
      end else if (ram_we) begin
        wp_r    <= wp_nxt;
      end
      // writes fill the store from entry zero upward, so written entries form a prefix
      if (ram_we && (sfdl_pkg::len_t'(wp_r) >= hw_r)) begin
        hw_r <= wp_inc;
      end
      if (en) begin
        vp_r   <= in_ch.valid;
        v1_r   <= vp_r;
        sa_v_r <= v1_r;
        sb_v_r <= sa_v_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      p_in_r.left  <= in_ch.left_in;
      p_in_r.right <= in_ch.right_in;
      p_back_r     <= back_nxt;
      p_bk1_r      <= bk1_nxt;
      p_frac_r     <= frac_nxt;
      p_zero_r     <= zero_nxt;
      p_mute_r     <= in_ch.delay_bad;
      s1_mute_r    <= p_mute_r;
      s1_zero_r    <= p_zero_r;
      s1_va_r      <= first_ok;
      s1_vb_r      <= next_ok;
      s1_frac_r    <= p_frac_r;
      s1_in_r      <= p_in_r;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions

  // input stalls only while a result is waiting at the output
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no pending result");

  // both interpolation taps lie inside the active ring
  a_taps_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vp_r && !p_zero_r) |->
      (sfdl_pkg::len_t'(rd_first) < len_r) && (sfdl_pkg::len_t'(rd_next) < len_r))
    else $error("tap address outside ring");

  // a written frame moves the write pointer
  a_wp_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && !cfg_we) |=> (wp_r != $past(wp_r)))
    else $error("write pointer did not advance");

  // the high-water mark covers every written entry
  a_hw_covers: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (hw_r > sfdl_pkg::len_t'($past(wp_r))))
    else $error("high-water mark behind written entry");

endmodule

FILE: tb/sfdl_checker.sv
// Scoreboard for the stereo fractional delay line: predicts each output frame and compares it.
module sfdl_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  sfdl_pkg::len_t      cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  sfdl_pkg::sample_t   in_left,
  input  sfdl_pkg::sample_t   in_right,
  input  sfdl_pkg::delay_t    in_delay,
  input  logic                in_bad,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sfdl_pkg::sample_t   out_left,
  input  sfdl_pkg::sample_t   out_right,
  output int                  mismatches,
  output int                  frames_waiting
);
  import sfdl_pkg::*;

  sample_t left_mem [STORE_DEPTH];
  sample_t right_mem [STORE_DEPTH];
  longint unsigned wr_pos;
  len_t ring_reg;
  frame_t due_q [$];

  function automatic longint unsigned used_length();
    longint unsigned n;
    n = 64'(ring_reg);
    if (n < 64'(MIN_RING)) n = 64'(MIN_RING);
    if (n > 64'(STORE_DEPTH)) n = 64'(STORE_DEPTH);
    return n;
  endfunction

  // a + floor(((b - a) * frac + half) / 2^FRACTION_BITS)
  function automatic sample_t lerp(sample_t a, sample_t b, frac_t f);
    longint sa, sb, fl, t;
    sa = 64'(a);
    sb = 64'(b);
    fl = 64'(f);
    t = (sb - sa) * fl + (longint'(1) << (FRACTION_BITS - 1));
    return sample_t'(sa + (t >>> FRACTION_BITS));
  endfunction

  // Unless the frame is bad, advances the predicted store and write pointer; returns the output frame.
  function automatic frame_t delayed_frame(sample_t l, sample_t r, delay_t dly, logic bad);
    longint unsigned n, wp, d, lim, span, pos, first, nxt;
    frac_t fr;
    frame_t res;
    n = used_length();
    if (bad) return '0;
    wp = wr_pos;
    if (wp >= n) wp = 0;
    d = 64'(dly);
    lim = (n - 64'(GUARD_FRAMES)) << FRACTION_BITS;
    if (d > lim) d = lim;
    if (d == 0) begin
      res.left = l;
      res.right = r;
    end else begin
      span = n << FRACTION_BITS;
      pos = (wp << FRACTION_BITS) + span - d;
      if (pos >= span) pos -= span;
      first = pos >> FRACTION_BITS;
      fr = frac_t'(pos);
      nxt = first + 1;
      if (nxt >= n) nxt = 0;
      res.left = lerp(left_mem[first[ADDR_BITS-1:0]], left_mem[nxt[ADDR_BITS-1:0]], fr);
      res.right = lerp(right_mem[first[ADDR_BITS-1:0]], right_mem[nxt[ADDR_BITS-1:0]], fr);
    end
    // read happens before write
    left_mem[wp[ADDR_BITS-1:0]] = l;
    right_mem[wp[ADDR_BITS-1:0]] = r;
    wp++;
    if (wp >= n) wp = 0;
    wr_pos = wp;
    return res;
  endfunction

  always @(posedge clk) begin
    frame_t wanted;
    if (!rst_n) begin
      foreach (left_mem[i]) begin
        left_mem[i] = '0;
        right_mem[i] = '0;
      end
      wr_pos = 0;
      ring_reg = RING_MAX;
      due_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        ring_reg = cfg_wdata;
        wr_pos = 0;
      end
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $error("output frame with nothing pending: left_out %0d, right_out %0d",
                 out_left, out_right);
          mismatches++;
        end else begin
          wanted = due_q.pop_front();
          if (out_left !== wanted.left) begin
            $error("left_out: expected %0d, got %0d", wanted.left, out_left);
            mismatches++;
          end
          if (out_right !== wanted.right) begin
            $error("right_out: expected %0d, got %0d", wanted.right, out_right);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        due_q.push_back(delayed_frame(in_left, in_right, in_delay, in_bad));
    end
    frames_waiting = due_q.size();
  end

endmodule

FILE: tb/tb_stereo_fractional_delay_line.sv
// Testbench top: stimulus, ring-length phases and verdict for the stereo delay line.
module tb_stereo_fractional_delay_line;
  import sfdl_pkg::*;

  // Give the pipe and skid slack before the next step.
  localparam int unsigned DRAIN_CYCLES = 12;

  localparam sample_t FULL_POS   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t FULL_NEG   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam sample_t MINUS_ONE  = '1;
  localparam delay_t  ONE_FRAME  = delay_t'(1 << FRACTION_BITS);
  localparam delay_t  HALF_FRAME = delay_t'(1 << (FRACTION_BITS - 1));
  localparam delay_t  DELAY_ALL  = '1;
  localparam delay_t  DELAY_TOP  = delay_t'(1) << (DELAY_BITS - 1);
  // Longest legal delay at the full ring: STORE_DEPTH - 2 frames.
  localparam delay_t  DELAY_EDGE = delay_t'(SPAN_MAX) << FRACTION_BITS;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  len_t cfg_wdata;

  sfdl_in_if  in_ch ();
  sfdl_out_if out_ch ();

  int mismatches;
  int frames_waiting;

  // Stimulus bookkeeping
  bit          no_idle;        // phase without gaps or stalls
  int unsigned ready_hold = 0; // cycles left in the current output stall
  int unsigned cur_len;        // ring length the block is actually using
  int          sent_frames;
  int          bad_frames;
  int          ring_writes;

  always #1 clk = ~clk;

  stereo_fractional_delay_line dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  sfdl_checker scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_left        (in_ch.left_in),
    .in_right       (in_ch.right_in),
    .in_delay       (in_ch.delay_in),
    .in_bad         (in_ch.delay_bad),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_left       (out_ch.left_out),
    .out_right      (out_ch.right_out),
    .mismatches     (mismatches),
    .frames_waiting (frames_waiting)
  );

  // Mostly back-to-back, some short gaps, the odd long one.
  function automatic int unsigned gap_len();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned ring_used(len_t v);
    if (v < RING_MIN) return MIN_RING;
    if (v > RING_MAX) return STORE_DEPTH;
    return 32'(v);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 39))
      0:       return FULL_POS;
      1:       return FULL_NEG;
      2:       return '0;
      3:       return MINUS_ONE;
      default: return sample_t'($urandom());
    endcase
  endfunction

  // Output side: ready high, then a random stall, which is often empty.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      out_ch.ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
      ready_hold <= gap_len();
    end
  end

  // One input transaction: optional gap, then hold valid until ready is seen.
  task automatic push_frame(sample_t l, sample_t r, delay_t d, logic bad);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.left_in   <= l;
    in_ch.right_in  <= r;
    in_ch.delay_in  <= d;
    in_ch.delay_bad <= bad;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_frames++;
    if (bad) bad_frames++;
  endtask

  // Stop sending and let every pending frame come out before touching the register.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_ring(len_t v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_len = ring_used(v);
    ring_writes++;
  endtask

  // Random frames: mostly legal delays into written history, plus zero delays,
  // clamped delays, raw 28-bit delays and the odd bad-delay flag.
  task automatic random_frames(int count);
    int unsigned roll, lim;
    delay_t d;
    logic bad;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      lim = (cur_len - GUARD_FRAMES) << FRACTION_BITS;
      bad = 1'b0;
      if (roll < 5) begin
        bad = 1'b1;
        d = delay_t'($urandom());
      end else if (roll < 12) begin
        d = '0;
      end else if (roll < 20) begin
        d = delay_t'($urandom());
      end else if (roll < 25) begin
        d = delay_t'(lim + $urandom_range(0, 3));
      end else if (cur_len > 64 && $urandom_range(0, 1) == 1) begin
        // keep the read point inside recently written entries
        d = delay_t'($urandom_range(0, 32 << FRACTION_BITS));
      end else begin
        d = delay_t'($urandom_range(0, lim));
      end
      push_frame(pick_sample(), pick_sample(), d, bad);
    end
  endtask

  initial begin
    len_t ring_val;
    int   n_frames;

    // Everything driven known from time zero.
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.left_in      = '0;
    in_ch.right_in     = '0;
    in_ch.delay_in     = '0;
    in_ch.delay_bad    = 1'b0;
    no_idle            = 1'b0;
    cur_len            = STORE_DEPTH;
    sent_frames        = 0;
    bad_frames         = 0;
    ring_writes        = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, full ring after reset, write pointer starts at entry 0.
    push_frame(FULL_POS, FULL_NEG, '0, 1'b0);              // zero delay passes through
    push_frame(FULL_NEG, FULL_POS, '0, 1'b0);
    push_frame(MINUS_ONE, sample_t'(1), ONE_FRAME, 1'b0);  // whole frame back
    push_frame(FULL_POS, '0, HALF_FRAME, 1'b0);            // next entry is the old write slot
    push_frame(sample_t'(12345), FULL_NEG, delay_t'(1), 1'b0);   // tiniest fraction
    push_frame(FULL_NEG, FULL_POS, delay_t'(16'hFFFF), 1'b0);   // just under one frame
    push_frame(sample_t'(-777), sample_t'(777), delay_t'(32'h24000), 1'b0);
    push_frame(FULL_POS, FULL_POS, DELAY_ALL, 1'b0);       // clamps to ring - 2
    push_frame(FULL_NEG, FULL_NEG, DELAY_EDGE, 1'b0);      // exactly the limit
    push_frame('0, MINUS_ONE, DELAY_EDGE + delay_t'(1), 1'b0);
    push_frame(sample_t'(100), sample_t'(-100), DELAY_TOP, 1'b0);
    push_frame(FULL_POS, FULL_NEG, DELAY_ALL, 1'b1);       // bad delay mutes, no write
    push_frame(FULL_NEG, FULL_POS, '0, 1'b1);
    push_frame(sample_t'(42), sample_t'(-42), delay_t'(32'h18000), 1'b0);

    // Shortest ring: the next-entry index wraps, big delays clamp to one frame.
    set_ring(RING_MIN);
    push_frame(FULL_POS, FULL_NEG, '0, 1'b0);
    push_frame(FULL_NEG, FULL_POS, '0, 1'b0);
    push_frame(sample_t'(5000), sample_t'(-5000), '0, 1'b0);
    push_frame(MINUS_ONE, sample_t'(1), HALF_FRAME, 1'b0);   // reads last entry and entry 0
    push_frame(FULL_POS, '0, ONE_FRAME, 1'b0);
    push_frame('0, FULL_POS, DELAY_ALL, 1'b0);
    push_frame(FULL_NEG, MINUS_ONE, delay_t'(32'h1FFFF), 1'b0);
    push_frame('0, '0, HALF_FRAME, 1'b1);
    random_frames(50);

    // Ring-length phases, extremes of the register included; every third
    // phase runs with no gaps and no stalls.
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin ring_val = '0;                                n_frames = 40; end
        1: begin ring_val = len_t'(1);                         n_frames = 30; end
        2: begin ring_val = len_t'(2);                         n_frames = 30; end
        3: begin ring_val = len_t'(5);                         n_frames = 60; end
        4: begin ring_val = len_t'(17);                        n_frames = 70; end
        5: begin ring_val = '1;                                n_frames = 50; end
        6: begin ring_val = len_t'(64);                        n_frames = 60; end
        7: begin ring_val = RING_MAX;                          n_frames = 60; end
        8: begin ring_val = len_t'($urandom_range(4, 40));     n_frames = 60; end
        default: begin ring_val = len_t'($urandom());          n_frames = 60; end
      endcase
      set_ring(ring_val);
      no_idle = (p % 3 == 1);
      random_frames(n_frames);
    end

    settle();
    $display("Ran %0d frames (%0d with a bad delay) over %0d ring-length writes,",
             sent_frames, bad_frames, ring_writes);
    $display("with random input gaps and output stalls on most phases.");
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
sv/sfdl_pkg.sv
sv/sfdl_if.sv
sv/sfdl_ram.sv
sv/sfdl_blend.sv
sv/sfdl_outq.sv
sv/stereo_fractional_delay_line.sv
tb/sfdl_checker.sv
tb/tb_stereo_fractional_delay_line.sv
